FILE: hdl/bgq_pkg.sv
// Shared types, codes and helpers for the bitset graph query engine.
// Depends on nothing; the top and the count unit import it.
`timescale 1ns / 1ps

package bgq_pkg;

    localparam int WORD_W = 64;
    localparam int COUNT_W = 22;
    localparam int EDGE_W = 15;
    localparam int NODE_W = 8;
    localparam int NCNT_W = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 22'h3FFFFF;
    localparam logic [EDGE_W-1:0] EDGE_MAX = 15'h7FFF;
    localparam logic [NCNT_W-1:0] NODE_COUNT_RESET = 9'd256;

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_HAS = 3'd1;
    localparam logic [2:0] KIND_DEG = 3'd2;
    localparam logic [2:0] KIND_COM = 3'd3;
    localparam logic [2:0] KIND_TRI = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } req_t;

    typedef struct packed {
        logic found;
        logic rejected;
        logic [COUNT_W-1:0] count;
        logic [EDGE_W-1:0] edge_total;
    } rsp_t;

    // Control from sequencer to count unit
    typedef struct packed {
        logic clr;
        logic issue;
        logic use_b;
    } cnt_ctl_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_EDGE_RD,
        ST_EDGE_WB,
        ST_ROW_ISSUE,
        ST_TRI_ROW,
        ST_TRI_LOAD,
        ST_TRI_SCAN,
        ST_TRI_INNER,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Bits of a word whose position is above bit_pos
    function automatic logic [WORD_W-1:0] above_in_word(input logic [5:0] bit_pos);
        logic [6:0] sh;
        sh = 7'(bit_pos) + 7'd1;
        above_in_word = {WORD_W{1'b1}} << sh;
    endfunction

    function automatic logic [6:0] pop64(input logic [WORD_W-1:0] x);
        logic [6:0] c;
        c = '0;
        for (int i = 0; i < WORD_W; i++) begin
            c = c + 7'(x[i]);
        end
        pop64 = c;
    endfunction

endpackage

FILE: hdl/bitset_graph_query_engine_top.sv
// Bitset graph query engine: adjacency matrix in RAM, sequencer on top.
// Triangle count walks each u in range over its row words from u/64 up, and for each
// neighbor v above u over the row words from v/64 up. One request at a time: the next is
// taken in the cycle after the output register loads. Reset: a clearing pass writes
// MAX_NODES*ROW_WORDS zero words before the first request; config writes anytime.
`timescale 1ns / 1ps

module bitset_graph_query_engine_top #(
    parameter int MAX_NODES = 256,
    parameter int ROW_WORDS = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  bgq_pkg::req_t              req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output bgq_pkg::rsp_t              rsp,
    input  logic                       cfg_we,
    input  logic [bgq_pkg::NCNT_W-1:0] cfg_wdata
);
    import bgq_pkg::*;

    localparam int DEPTH   = MAX_NODES * ROW_WORDS;
    localparam int AW      = $clog2(DEPTH);
    localparam int KW      = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int COL_W   = KW + 6;
    localparam int COL_MAX = ROW_WORDS * 64;
    localparam int CAP     = (MAX_NODES < COL_MAX) ? MAX_NODES : COL_MAX;
    localparam int LIM_W   = $clog2(CAP + 1);
    localparam int LW      = (LIM_W > NCNT_W) ? LIM_W : NCNT_W;
    localparam logic [KW-1:0] KLAST = KW'(ROW_WORDS - 1);
    localparam logic [AW-1:0] ALAST = AW'(DEPTH - 1);

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    logic [NCNT_W-1:0]   node_count_reg;
    logic [EDGE_W-1:0]   edge_cnt_reg, edge_cnt_next;
    logic [COL_W-1:0]    u_reg, u_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [KW-1:0]       k2_reg, k2_next;
    logic [5:0]          vbit_reg, vbit_next;
    logic [WORD_W-1:0]   scan_reg, scan_next;
    logic                found_reg, found_next;
    logic                rejected_reg, rejected_next;
    logic [AW-1:0]       clr_reg, clr_next;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [WORD_W-1:0]   ram_wdata, rdata_a, rdata_b;
    cnt_ctl_t            cnt_ctl;
    logic [WORD_W-1:0]   cnt_mask;
    logic [COUNT_W-1:0]  acc;

    logic [LW-1:0]       limit;
    logic                a_ok, b_ok, a_ne_b;
    logic [COL_W-1:0]    a_col, b_col, u_inc, v_col;
    logic [AW-1:0]       addr_ea, addr_eb;
    logic                edge_bit, u_last, v_in, rsp_load;
    logic [WORD_W-1:0]   lsb;
    logic [5:0]          idx;

    function automatic logic [AW-1:0] row_addr(input logic [COL_W-1:0] node,
                                               input logic [KW-1:0] k);
        row_addr = AW'(32'(node) * ROW_WORDS + 32'(k));
    endfunction

    // Decode request operands
    always_comb
    begin
        limit  = (LW'(node_count_reg) > LW'(CAP)) ? LW'(CAP) : LW'(node_count_reg);
        a_ok   = LW'(req_reg.node_a) < limit;
        b_ok   = LW'(req_reg.node_b) < limit;
        a_ne_b = req_reg.node_a != req_reg.node_b;
        a_col  = COL_W'(req_reg.node_a);
        b_col  = COL_W'(req_reg.node_b);
        addr_ea = row_addr(a_col, b_col[COL_W-1:6]);
        addr_eb = row_addr(b_col, a_col[COL_W-1:6]);
        edge_bit = rdata_a[req_reg.node_b[5:0]];
        u_inc  = u_reg + COL_W'(1);
        u_last = (32'(u_reg) + 1) == 32'(limit);
    end

    // Find the lowest set neighbor bit of the scan word
    always_comb
    begin
        lsb = scan_reg & (~scan_reg + WORD_W'(1));
        idx = '0;
        for (int j = 0; j < 6; j++)
        begin
            for (int i = 0; i < WORD_W; i++)
            begin
                if (((i >> j) & 1) == 1)
                begin
                    idx[j] = idx[j] | lsb[i];
                end
            end
        end
        v_col = {k_reg, idx};
        v_in  = 32'(v_col) < MAX_NODES;
    end

    assign rsp_load = !rsp_valid_reg || rsp_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == ALAST) state_next = ST_IDLE;
            ST_IDLE:
                if (req_valid) state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                case (req_reg.kind)
                    KIND_ADD:
                        state_next = (a_ne_b && a_ok && b_ok) ? ST_EDGE_RD : ST_DONE;
                    KIND_HAS:
                        state_next = (a_ne_b && a_ok && b_ok) ? ST_EDGE_RD : ST_DONE;
                    KIND_DEG:
                        state_next = a_ok ? ST_ROW_ISSUE : ST_DONE;
                    KIND_COM:
                        state_next = (a_ne_b && a_ok && b_ok) ? ST_ROW_ISSUE : ST_DONE;
                    KIND_TRI:
                        state_next = (limit != '0) ? ST_TRI_ROW : ST_DONE;
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_EDGE_RD:
                state_next = (req_reg.kind == KIND_ADD && !edge_bit) ? ST_EDGE_WB : ST_DONE;
            ST_EDGE_WB:
                state_next = ST_DONE;
            ST_ROW_ISSUE:
                if (k_reg == KLAST) state_next = ST_DRAIN;
            ST_TRI_ROW:
                state_next = ST_TRI_LOAD;
            ST_TRI_LOAD:
                state_next = ST_TRI_SCAN;
            ST_TRI_SCAN:
            begin
                if (scan_reg == '0)
                begin
                    if (k_reg != KLAST)
                        state_next = ST_TRI_ROW;
                    else
                        state_next = u_last ? ST_DRAIN : ST_TRI_ROW;
                end
                else if (v_in)
                begin
                    state_next = ST_TRI_INNER;
                end
            end
            ST_TRI_INNER:
                if (k2_reg == KLAST) state_next = ST_TRI_SCAN;
            ST_DRAIN:
                state_next = ST_DONE;
            ST_DONE:
                if (rsp_load) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        req_next       = req_reg;
        edge_cnt_next  = edge_cnt_reg;
        u_next         = u_reg;
        k_next         = k_reg;
        k2_next        = k2_reg;
        vbit_next      = vbit_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        rejected_next  = rejected_reg;
        clr_next       = clr_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ram_we         = 1'b0;
        ram_waddr      = addr_ea;
        ram_wdata      = rdata_a | (WORD_W'(1) << req_reg.node_b[5:0]);
        ram_raddr_a    = addr_ea;
        ram_raddr_b    = addr_eb;
        cnt_ctl        = '0;
        cnt_mask       = {WORD_W{1'b1}};
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
            end
            ST_IDLE:
                if (req_valid) req_next = req;
            ST_DISPATCH:
            begin
                found_next    = 1'b0;
                rejected_next = (req_reg.kind == KIND_ADD) && !(a_ne_b && a_ok && b_ok);
                cnt_ctl.clr   = 1'b1;
                k_next        = '0;
                u_next        = '0;
            end
            ST_EDGE_RD:
            begin
                // Test the bit; an add of an absent edge also sets its first half
                if (req_reg.kind == KIND_HAS)
                    found_next = edge_bit;
                else if (edge_bit)
                    rejected_next = 1'b1;
                else
                    ram_we = 1'b1;
            end
            ST_EDGE_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_eb;
                ram_wdata = rdata_b | (WORD_W'(1) << req_reg.node_a[5:0]);
                if (edge_cnt_reg != EDGE_MAX) edge_cnt_next = edge_cnt_reg + EDGE_W'(1);
            end
            ST_ROW_ISSUE:
            begin
                ram_raddr_a   = row_addr(a_col, k_reg);
                ram_raddr_b   = row_addr(b_col, k_reg);
                cnt_ctl.issue = 1'b1;
                cnt_ctl.use_b = req_reg.kind == KIND_COM;
                k_next        = k_reg + KW'(1);
            end
            ST_TRI_ROW:
                ram_raddr_a = row_addr(u_reg, k_reg);
            ST_TRI_LOAD:
                scan_next = rdata_a & ((k_reg == u_reg[COL_W-1:6]) ?
                            above_in_word(u_reg[5:0]) : {WORD_W{1'b1}});
            ST_TRI_SCAN:
            begin
                if (scan_reg == '0)
                begin
                    // Advance to the next word, or to the next row
                    if (k_reg != KLAST)
                    begin
                        k_next = k_reg + KW'(1);
                    end
                    else
                    begin
                        u_next = u_inc;
                        k_next = u_inc[COL_W-1:6];
                    end
                end
                else
                begin
                    scan_next = scan_reg & (scan_reg - WORD_W'(1));
                    vbit_next = idx;
                    k2_next   = k_reg;
                end
            end
            ST_TRI_INNER:
            begin
                ram_raddr_a   = row_addr(u_reg, k2_reg);
                ram_raddr_b   = row_addr({k_reg, vbit_reg}, k2_reg);
                cnt_ctl.issue = 1'b1;
                cnt_ctl.use_b = 1'b1;
                cnt_mask      = (k2_reg == k_reg) ? above_in_word(vbit_reg) : {WORD_W{1'b1}};
                k2_next       = k2_reg + KW'(1);
            end
            ST_DRAIN:
            begin
            end
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    rsp_next.found      = found_reg;
                    rsp_next.rejected   = rejected_reg;
                    rsp_next.count      = acc;
                    rsp_next.edge_total = edge_cnt_reg;
                    rsp_valid_next      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            edge_cnt_reg   <= '0;
            node_count_reg <= NODE_COUNT_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            edge_cnt_reg  <= edge_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we) node_count_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        u_reg        <= u_next;
        k_reg        <= k_next;
        k2_reg       <= k2_next;
        vbit_reg     <= vbit_next;
        scan_reg     <= scan_next;
        found_reg    <= found_next;
        rejected_reg <= rejected_next;
        rsp_reg      <= rsp_next;
    end

    bgq_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_matrix (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr_a(ram_raddr_a),
        .raddr_b(ram_raddr_b),
        .rdata_a(rdata_a),
        .rdata_b(rdata_b)
    );

    bgq_count_unit u_count (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(cnt_ctl),
        .mask(cnt_mask),
        .rdata_a(rdata_a),
        .rdata_b(rdata_b),
        .count(acc)
    );

    assign req_ready = state_reg == ST_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: hdl/bgq_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// Depends on nothing.
`timescale 1ns / 1ps

module bgq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register both reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: hdl/bgq_count_unit.sv
// Saturating popcount accumulator fed by the matrix memory read ports.
// Depends on bgq_pkg.
`timescale 1ns / 1ps

module bgq_count_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bgq_pkg::cnt_ctl_t              ctl,
    input  logic [bgq_pkg::WORD_W-1:0]     mask,
    input  logic [bgq_pkg::WORD_W-1:0]     rdata_a,
    input  logic [bgq_pkg::WORD_W-1:0]     rdata_b,
    output logic [bgq_pkg::COUNT_W-1:0]    count
);
    import bgq_pkg::*;

    logic               pend_reg;
    logic               use_b_reg;
    logic [WORD_W-1:0]  mask_reg;
    logic [COUNT_W-1:0] acc_reg;
    logic [COUNT_W-1:0] acc_next;
    logic [WORD_W-1:0]  word;
    logic [COUNT_W:0]   sum;

    // Combine the word that arrives in the cycle after its read was issued
    always_comb
    begin
        word = rdata_a & (use_b_reg ? rdata_b : {WORD_W{1'b1}}) & mask_reg;
        sum = {1'b0, acc_reg} + (COUNT_W+1)'(pop64(word));
        acc_next = acc_reg;
        if (ctl.clr)
        begin
            acc_next = '0;
        end
        else if (pend_reg)
        begin
            acc_next = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            pend_reg <= ctl.issue;
            acc_reg  <= acc_next;
        end
    end

    // Hold the issue-side qualifiers for the data cycle
    always_ff @(posedge clk)
    begin
        use_b_reg <= ctl.use_b;
        mask_reg  <= mask;
    end

    assign count = acc_reg;

endmodule
